[sv/i2r_pkg.sv]
package i2r_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;

  localparam int RADIX_W  = 6;
  localparam int DIGIT_W  = 6;
  localparam int CHAR_W   = 7;
  localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W    = $clog2(MAX_DIGITS);
  localparam int BIT_W    = $clog2(VALUE_WIDTH);

  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = 36;
  localparam int RADIX_RESET = 10;

  localparam int DEC_DIGIT_MAX = 9;
  localparam int ZERO_CHAR     = 48;
  localparam int ALPHA_OFFSET  = 55;

  typedef struct packed {
    logic load;
    logic step;
    logic emit_start;
    logic rd;
    logic out_load;
  } i2r_cmd_t;

  typedef struct packed {
    logic step_last;
    logic q_zero;
    logic count_full;
    logic idx_zero;
    logic out_free;
  } i2r_status_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (int'(d) <= DEC_DIGIT_MAX) begin
      c = CHAR_W'(ZERO_CHAR + int'(d));
    end else begin
      c = CHAR_W'(ALPHA_OFFSET + int'(d));
    end
    return c;
  endfunction

endpackage

[sv/i2r_ctrl.sv]
module i2r_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2r_pkg::i2r_status_t status,
  output i2r_pkg::i2r_cmd_t    cmd
);
  import i2r_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_READ,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.step_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.q_zero || status.count_full) begin
          cmd.emit_start = 1'b1;
          state_next     = S_READ;
        end else begin
          state_next = S_DIV;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = status.idx_zero ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/i2r_datapath.sv]
module i2r_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i2r_pkg::RADIX_W-1:0]       cfg_data,
  input  logic [i2r_pkg::VALUE_WIDTH-1:0]   value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [i2r_pkg::CHAR_W-1:0]        digit_char,
  output logic                              last_char,
  input  i2r_pkg::i2r_cmd_t                 cmd,
  output i2r_pkg::i2r_status_t              status
);
  import i2r_pkg::*;

  logic [RADIX_W-1:0]     radix;
  logic [RADIX_W-1:0]     base;
  logic [VALUE_WIDTH-1:0] quot;
  logic [VALUE_WIDTH-1:0] quot_next;
  logic [DIGIT_W-1:0]     rem;
  logic [DIGIT_W-1:0]     rem_next;
  logic [DIGIT_W:0]       partial;
  logic                   fits;
  logic [BIT_W-1:0]       bit_cnt;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       rd_idx;
  logic [DIGIT_W-1:0]     rd_data;
  logic [DIGIT_W-1:0]     digit_store [MAX_DIGITS];

  assign cfg_ready = 1'b1;

  always_comb begin
    if (radix < RADIX_W'(RADIX_MIN)) begin
      base = RADIX_W'(RADIX_MIN);
    end else if (radix > RADIX_W'(RADIX_MAX)) begin
      base = RADIX_W'(RADIX_MAX);
    end else begin
      base = radix;
    end
  end

  // one restoring division step
  assign partial   = {rem, quot[VALUE_WIDTH-1]};
  assign fits      = partial >= {1'b0, base};
  assign rem_next  = fits ? DIGIT_W'(partial - {1'b0, base}) : partial[DIGIT_W-1:0];
  assign quot_next = {quot[VALUE_WIDTH-2:0], fits};

  assign status.step_last  = bit_cnt == BIT_W'(VALUE_WIDTH - 1);
  assign status.q_zero     = quot == '0;
  assign status.count_full = count == CNT_W'(MAX_DIGITS);
  assign status.idx_zero   = rd_idx == '0;
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_W'(RADIX_RESET);
      count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radix <= cfg_data;
      end
      if (cmd.load) begin
        count <= '0;
      end else if (cmd.step && status.step_last) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot    <= value;
      rem     <= '0;
      bit_cnt <= '0;
    end else if (cmd.step) begin
      quot <= quot_next;
      if (status.step_last) begin
        rem     <= '0;
        bit_cnt <= '0;
      end else begin
        rem     <= rem_next;
        bit_cnt <= bit_cnt + BIT_W'(1);
      end
    end
    if (cmd.emit_start) begin
      rd_idx <= IDX_W'(count - CNT_W'(1));
    end else if (cmd.out_load) begin
      rd_idx <= rd_idx - IDX_W'(1);
    end
  end

  // digit store, least significant digit at entry zero
  always_ff @(posedge clk) begin
    if (cmd.step && status.step_last) begin
      digit_store[count[IDX_W-1:0]] <= rem_next;
    end
    if (cmd.rd) begin
      rd_data <= digit_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      digit_char <= digit_to_ascii(rd_data);
      last_char  <= status.idx_zero;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !status.step_last) |=> rem < base)
    else $error("partial remainder not below radix");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten while stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded character not presented");

endmodule

[sv/integer_to_radix_ascii_core.sv]
// each digit takes one bit-serial division of the value, then a check of quotient and digit count
// each division is a restoring divide, one quotient bit per cycle
// characters then leave one at a time from a registered digit store read, waiting on out_stall
// a new value is taken only in idle, after the last character is loaded for output
// reset: synchronous active high, radix to 10, controller idle, output empty
// digit store is not cleared: every entry is written before it is read
module integer_to_radix_ascii_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2r_pkg::RADIX_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [i2r_pkg::VALUE_WIDTH-1:0] value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [i2r_pkg::CHAR_W-1:0]      digit_char,
  output logic                            last_char
);
  import i2r_pkg::*;

  i2r_cmd_t    cmd;
  i2r_status_t status;

  i2r_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  i2r_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last_char  (last_char),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
